>>> design/mtpwm_pkg.sv
// Shared constants, codes and types of the multichannel tick PWM core.
package mtpwm_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PACK_W   = (CHANNELS > 8) ? CHANNELS : 8;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned VAL_W    = 24;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned LEVELS_W = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned STEP_W   = $clog2(VAL_W + 1);

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RATE_ZERO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREQ_ZERO = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TICK = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/mtpwm_if.sv
// Channel interfaces of the multichannel tick PWM core.
interface mtpwm_in_if import mtpwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [VAL_W-1:0]  frequency;
  logic [VAL_W-1:0]  duty_ticks;
  logic [IDX_W-1:0]  channel_index;
  modport source (output valid, opcode, frequency, duty_ticks, channel_index, input ready);
  modport sink   (input valid, opcode, frequency, duty_ticks, channel_index, output ready);
endinterface

interface mtpwm_out_if import mtpwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEVELS_W-1:0] levels;
  logic [SLOT_W-1:0]   assigned_channel;
  logic [STATUS_W-1:0] status;
  modport source (output valid, levels, assigned_channel, status, input ready);
  modport sink   (input valid, levels, assigned_channel, status, output ready);
endinterface

interface mtpwm_cfg_if import mtpwm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> design/mtpwm_div.sv
// Restoring divider, one quotient bit per cycle.
module mtpwm_div import mtpwm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [VAL_W-1:0]  rem_q, rem_d;
  logic [VAL_W-1:0]  quo_q, quo_d;
  logic [VAL_W-1:0]  dsr_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [VAL_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[VAL_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? VAL_W'(trial - {1'b0, dsr_q}) : trial[VAL_W-1:0];
      quo_d  = {quo_q[VAL_W-2:0], fits};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(VAL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dsr_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> design/multichannel_tick_pwm_core.sv
// Top level of the multichannel tick PWM core.
//
// in_i carries one command per transfer: tick, add channel or update duty.
// out_o returns exactly one result per command: the packed levels of
// channels 0..7, the channel taken by a successful add and a status code.
// cfg_i writes tick_rate and is always ready; the user must write it only
// while idle; the core does not enforce it. From accept to result valid:
//   tick: one channel per cycle through one update unit
//   add:  through the bit-serial period divider when it succeeds,
//         straight to the result when it fails
//   update and unused opcode: straight to the result
// One command is in work at a time; in_i.ready is high only while idle.
// The next command can be accepted in the cycle after the result is loaded,
// so a new command is never taken before the last one is through.
// The result sits in an output register, so the next command is accepted
// while it waits; a stalled receiver holds the core in its final step only
// when a second result is ready before the first is taken.
// Reset frees every channel, drives every level low and clears tick_rate.
module multichannel_tick_pwm_core import mtpwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtpwm_in_if.sink    in_i,
  mtpwm_out_if.source out_o,
  mtpwm_cfg_if.sink   cfg_i
);

  state_e state_q, state_d;

  logic [VAL_W-1:0]    tick_rate_q;
  logic [CHANNELS-1:0] active_q;
  logic [CHANNELS-1:0] level_q;
  logic [VAL_W-1:0]    period_q [CHANNELS];
  logic [VAL_W-1:0]    duty_q   [CHANNELS];
  logic [VAL_W-1:0]    count_q  [CHANNELS];

  logic [CH_W-1:0]     ch_q;
  logic [CH_W-1:0]     slot_q;
  logic [VAL_W-1:0]    add_duty_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;

  logic                out_valid_q;
  logic [LEVELS_W-1:0] out_levels_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [STATUS_W-1:0] out_status_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_xfer;
  logic              free_found;
  logic [CH_W-1:0]   free_idx;
  logic [5:0]        idx_ext;
  logic              idx_ok;
  logic [CH_W-1:0]   upd_idx;
  logic              out_load;
  logic [PACK_W-1:0] pack_full;

  logic [VAL_W-1:0] t_inc;
  logic             t_wrap;
  logic [VAL_W-1:0] t_cnt;
  logic             t_lvl;
  logic [VAL_W-1:0] per;
  logic [VAL_W-1:0] clamp_duty;

  mtpwm_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = in_i.valid && in_i.ready;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (!active_q[c]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(c);
      end
    end
  end

  assign idx_ext = 6'(in_i.channel_index);
  assign idx_ok  = idx_ext < 6'(CHANNELS);
  assign upd_idx = CH_W'(in_i.channel_index);

  assign t_inc  = count_q[ch_q] + VAL_W'(1);
  assign t_wrap = t_inc >= period_q[ch_q];
  assign t_cnt  = t_wrap ? '0 : t_inc;
  always_comb begin
    t_lvl = t_wrap ? (duty_q[ch_q] != '0) : level_q[ch_q];
    if ((duty_q[ch_q] != '0) && (t_cnt >= duty_q[ch_q])) begin
      t_lvl = 1'b0;
    end
  end

  assign per        = div_rsp.quotient;
  assign clamp_duty = (add_duty_q > per) ? per : add_duty_q;

  assign div_req.start    = in_xfer && (in_i.opcode == OP_ADD) && free_found &&
                            (tick_rate_q != '0) && (in_i.frequency != '0);
  assign div_req.dividend = tick_rate_q;
  assign div_req.divisor  = in_i.frequency;

  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign pack_full = PACK_W'(active_q & level_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_i.opcode == OP_TICK) begin
            state_d = S_TICK;
          end else if (div_req.start) begin
            state_d = S_DIV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_TICK: begin
        if (ch_q == CH_W'(CHANNELS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_rate_q <= '0;
      active_q    <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        tick_rate_q <= cfg_i.data;
      end
      if (in_xfer) begin
        ch_q <= '0;
      end else if (state_q == S_TICK) begin
        ch_q <= ch_q + CH_W'(1);
        if (active_q[ch_q]) begin
          level_q[ch_q] <= t_lvl;
        end
      end
      if ((state_q == S_DIV) && div_rsp.done) begin
        active_q[slot_q] <= 1'b1;
        level_q[slot_q]  <= (per != '0) && (clamp_duty != '0);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      slot_q       <= free_idx;
      add_duty_q   <= in_i.duty_ticks;
      res_status_q <= ST_OK;
      res_slot_q   <= '0;
      case (in_i.opcode)
        OP_ADD: begin
          if (!free_found) begin
            res_status_q <= ST_NO_FREE;
          end else if (tick_rate_q == '0) begin
            res_status_q <= ST_RATE_ZERO;
          end else if (in_i.frequency == '0) begin
            res_status_q <= ST_FREQ_ZERO;
          end else begin
            res_slot_q <= SLOT_W'(free_idx);
          end
        end
        OP_UPDATE: begin
          if (idx_ok) begin
            duty_q[upd_idx] <= in_i.duty_ticks;
          end else begin
            res_status_q <= ST_BAD_INDEX;
          end
        end
        default: ;
      endcase
    end
    if ((state_q == S_TICK) && active_q[ch_q]) begin
      count_q[ch_q] <= t_cnt;
    end
    if ((state_q == S_DIV) && div_rsp.done) begin
      period_q[slot_q] <= per;
      duty_q[slot_q]   <= clamp_duty;
      count_q[slot_q]  <= '0;
    end
    if (out_load) begin
      out_levels_q <= pack_full[LEVELS_W-1:0];
      out_slot_q   <= res_slot_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.levels           = out_levels_q;
  assign out_o.assigned_channel = out_slot_q;
  assign out_o.status           = out_status_q;

endmodule
